/* src/vmcs_pkg.sv */
// Shared types and constants for the voxel min/max contrast stretch block.
`default_nettype none
package vmcs_pkg;

    // Command codes carried by an input word.
    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_MEASURE = 2'd1;
    localparam logic [1:0] CMD_CONVERT = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_BIT_DEPTH      = 2'd0;
    localparam logic [1:0] REG_STRETCH_ENABLE = 2'd1;
    localparam logic [1:0] REG_BIG_ENDIAN     = 2'd2;
    localparam logic [1:0] REG_DST_WIDE       = 2'd3;

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    localparam logic [4:0] RST_BIT_DEPTH      = 5'd8;
    localparam logic       RST_STRETCH_ENABLE = 1'b1;
    localparam logic       RST_BIG_ENDIAN     = 1'b1;
    localparam logic       RST_DST_WIDE       = 1'b0;

    localparam logic [15:0] TOP_NARROW = 16'h00FF;
    localparam logic [15:0] TOP_WIDE   = 16'hFFFF;

    typedef struct packed {
        logic [4:0] bit_depth;
        logic       stretch_enable;
        logic       big_endian;
        logic       dst_wide;
    } cfg_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } div_stat_t;

endpackage
`default_nettype wire

/* src/voxel_minmax_contrast_stretch.sv */
// Voxel min/max contrast stretch: top level with sequencer, marks and output register.
// Clear and measure words give no result. A convert word with stretch disabled, or one
// that hits the stretch error, is accepted and its result goes through the pending
// register to the output register. A stretching convert runs the divider: 17 steps on
// one 17-bit compare/subtract (an overflow check and 16 quotient bits), then the quotient
// is taken into the pending register and from there into the output register; an
// overflowing quotient ends after the check. The input is not ready while a convert is in
// progress, and a finished result waits in the pending register while out_ready is low.
`default_nettype none
module voxel_minmax_contrast_stretch #(
    parameter int unsigned MAX_BIT_DEPTH = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     command,
    input  wire logic [15:0]                    sample_bytes,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [15:0]                    scaled_value,
    output logic                                scale_error,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [vmcs_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [vmcs_pkg::PDATA_W-1:0]   pwdata,
    output logic      [vmcs_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready
);
    import vmcs_pkg::*;

    localparam int unsigned LW = MAX_BIT_DEPTH + 1;
    localparam logic [4:0]  MAX_D = 5'(MAX_BIT_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_PUT  = 3'b100
    } state_t;

    cfg_t        cfg;
    div_stat_t   dstat;
    logic [15:0] quot;

    state_t      state_reg, state_next;
    logic [LW-1:0] low_reg, low_next;
    logic [15:0] high_reg, high_next;
    logic [15:0] pend_val_reg, pend_val_next;
    logic        pend_err_reg, pend_err_next;
    logic        ov_reg, ov_next;
    logic [15:0] oval_reg, oval_next;
    logic        oerr_reg, oerr_next;

    logic        accept;
    logic [4:0]  depth;
    logic [15:0] raw;
    logic [16:0] raw_ext, low_ext;
    logic [16:0] sdiff;
    logic [31:0] num;
    logic [15:0] den;
    logic        st_err;
    logic [23:0] prod;
    logic [23:0] prod_sh;
    logic [15:0] top;
    logic [15:0] plain_val;
    logic [15:0] div_val;
    logic        div_start;
    logic        out_free;

    vmcs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vmcs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .den   (den),
        .quot  (quot),
        .stat  (dstat)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid & in_ready;
    assign out_free = !ov_reg || out_ready;
    assign top      = cfg.dst_wide ? TOP_WIDE : TOP_NARROW;

    // Effective depth: zero acts as one, anything above the maximum acts as the maximum.
    always_comb
    begin
        if (cfg.bit_depth == 5'd0)
            depth = 5'd1;
        else if (cfg.bit_depth > MAX_D)
            depth = MAX_D;
        else
            depth = cfg.bit_depth;
    end

    always_comb
    begin
        if (depth <= 5'd8)
            raw = {8'd0, sample_bytes[15:8]};
        else if (cfg.big_endian)
            raw = sample_bytes;
        else
            raw = {sample_bytes[7:0], sample_bytes[15:8]};
    end

    assign raw_ext = {1'b0, raw};
    assign low_ext = 17'(low_reg);
    assign st_err  = ({1'b0, high_reg} <= low_ext) || (raw_ext < low_ext);
    assign sdiff   = raw_ext - low_ext;
    assign num     = {16'd0, sdiff[15:0]} << depth;
    assign den     = high_reg - low_ext[15:0];

    // raw * 255 as (raw << 8) - raw, then scaled down by the depth.
    assign prod    = {raw, 8'd0} - {8'd0, raw};
    assign prod_sh = prod >> depth;

    always_comb
    begin
        if (depth > 5'd8 && !cfg.dst_wide)
            plain_val = (prod_sh > {8'd0, top}) ? top : prod_sh[15:0];
        else
            plain_val = (raw > top) ? top : raw;
    end

    assign div_val   = (dstat.ovf || quot > top) ? top : quot;
    assign div_start = accept && command == CMD_CONVERT && cfg.stretch_enable && !st_err;

    always_comb
    begin
        state_next    = state_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        pend_val_next = pend_val_reg;
        pend_err_next = pend_err_reg;
        ov_next       = ov_reg && !out_ready;
        oval_next     = oval_reg;
        oerr_next     = oerr_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_CLEAR)
                    begin
                        low_next  = LW'(1) << depth;
                        high_next = '0;
                    end
                    else if (command == CMD_MEASURE)
                    begin
                        if (raw_ext < low_ext)
                            low_next = raw_ext[LW-1:0];
                        if (raw > high_reg)
                            high_next = raw;
                    end
                    else if (command == CMD_CONVERT)
                    begin
                        if (div_start)
                        begin
                            state_next = S_DIV;
                        end
                        else
                        begin
                            if (cfg.stretch_enable)
                            begin
                                pend_val_next = '0;
                                pend_err_next = 1'b1;
                            end
                            else
                            begin
                                pend_val_next = plain_val;
                                pend_err_next = 1'b0;
                            end
                            state_next = S_PUT;
                        end
                    end
                end
            end
            S_DIV:
            begin
                if (dstat.done)
                begin
                    pend_val_next = div_val;
                    pend_err_next = 1'b0;
                    state_next    = S_PUT;
                end
            end
            S_PUT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    oval_next  = pend_val_reg;
                    oerr_next  = pend_err_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            low_reg   <= LW'(1) << RST_BIT_DEPTH;
            high_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_val_reg <= pend_val_next;
        pend_err_reg <= pend_err_next;
        oval_reg     <= oval_next;
        oerr_reg     <= oerr_next;
    end

    assign out_valid    = ov_reg;
    assign scaled_value = oval_reg;
    assign scale_error  = oerr_reg;

endmodule
`default_nettype wire

/* src/vmcs_cfg.sv */
// APB configuration registers of the contrast stretch block.
`default_nettype none
module vmcs_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [vmcs_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [vmcs_pkg::PDATA_W-1:0]   pwdata,
    output logic      [vmcs_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,
    output vmcs_pkg::cfg_t                      cfg
);
    import vmcs_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_BIT_DEPTH:      cfg_next.bit_depth      = pwdata[4:0];
                REG_STRETCH_ENABLE: cfg_next.stretch_enable = pwdata[0];
                REG_BIG_ENDIAN:     cfg_next.big_endian     = pwdata[0];
                REG_DST_WIDE:       cfg_next.dst_wide       = pwdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_depth      <= RST_BIT_DEPTH;
            cfg_reg.stretch_enable <= RST_STRETCH_ENABLE;
            cfg_reg.big_endian     <= RST_BIG_ENDIAN;
            cfg_reg.dst_wide       <= RST_DST_WIDE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            REG_BIT_DEPTH:      prdata = {27'd0, cfg_reg.bit_depth};
            REG_STRETCH_ENABLE: prdata = {31'd0, cfg_reg.stretch_enable};
            REG_BIG_ENDIAN:     prdata = {31'd0, cfg_reg.big_endian};
            REG_DST_WIDE:       prdata = {31'd0, cfg_reg.dst_wide};
            default:            prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

/* src/vmcs_div.sv */
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one subtractor.
`default_nettype none
module vmcs_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [31:0]       num,
    input  wire logic [15:0]       den,
    output logic      [15:0]       quot,
    output vmcs_pkg::div_stat_t    stat
);
    import vmcs_pkg::*;

    typedef enum logic [2:0] {
        D_IDLE  = 3'b001,
        D_CHECK = 3'b010,
        D_RUN   = 3'b100
    } dstate_t;

    dstate_t     state_reg, state_next;
    logic [31:0] acc_reg, acc_next;
    logic [15:0] den_reg;
    logic [3:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic        ovf_reg, ovf_next;

    logic [16:0] operand;
    logic [17:0] diff;
    logic        ge;

    // The single compare/subtract shared by the overflow check and every quotient step.
    always_comb
    begin
        if (state_reg == D_CHECK)
            operand = {1'b0, acc_reg[31:16]};
        else
            operand = {acc_reg[31:16], acc_reg[15]};
        diff = {1'b0, operand} - {2'b00, den_reg};
        ge   = !diff[17];
    end

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        ovf_next   = ovf_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    acc_next   = num;
                    ovf_next   = 1'b0;
                    state_next = D_CHECK;
                end
            end
            D_CHECK:
            begin
                // A top half at or above the divisor means the quotient needs more than 16 bits.
                if (ge)
                begin
                    ovf_next   = 1'b1;
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                if (ge)
                    acc_next = {diff[15:0], acc_reg[14:0], 1'b1};
                else
                    acc_next = {operand[15:0], acc_reg[14:0], 1'b0};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start && state_reg == D_IDLE)
            den_reg <= den;
    end

    assign quot      = acc_reg[15:0];
    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;

endmodule
`default_nettype wire

/* src/vmcs_chk.sv */
// Port-level checker for the contrast stretch block, bound to the top level.
`default_nettype none
module vmcs_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [1:0]  command,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] scaled_value,
    input wire logic        scale_error
);
    import vmcs_pkg::*;

    // A result word holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(scaled_value) && $stable(scale_error))
        else $error("result word changed or dropped while stalled");

    // An error result always carries a zero value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scale_error |-> scaled_value == 16'd0)
        else $error("error result with nonzero value");

    // A clock edge seen in reset leaves no result word behind.
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result word valid after reset");

    // A convert word keeps the input busy on the following cycle.
    a_conv_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == CMD_CONVERT |=> !in_ready)
        else $error("input ready right after a convert word");

    // Clear and measure words never create a result word.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command != CMD_CONVERT && !out_valid |=> !out_valid)
        else $error("result word without a convert word");

endmodule

bind voxel_minmax_contrast_stretch vmcs_chk u_vmcs_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .scaled_value (scaled_value),
    .scale_error  (scale_error)
);
`default_nettype wire
